// File: design/dhm_pkg.sv
// Package for the device heartbeat monitor: request/result types,
// register indexes, request codes, colours and sequencer states. No dependencies.
package dhm_pkg;

  localparam int unsigned MaxDevices = 8;
  localparam int unsigned DefNumDevices = 8;

  localparam int unsigned DevIdxW = 3;
  localparam int unsigned ThrW = 16;
  localparam int unsigned LevelW = 3;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CntW = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [1:0] ReqBeat = 2'd0;
  localparam logic [1:0] ReqTick = 2'd1;
  localparam logic [1:0] ReqScan = 2'd2;

  localparam logic [CfgIdxW-1:0] RegThrLow = 3'd0;
  localparam logic [CfgIdxW-1:0] RegThrHigh = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLevels = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAim = 3'd3;
  localparam logic [CfgIdxW-1:0] RegReferee = 3'd4;

  localparam logic [63:0] ThrReset = 64'h00C8_00C8_00C8_00C8;
  localparam logic [DevIdxW-1:0] AimReset = 3'd0;
  localparam logic [DevIdxW-1:0] RefereeReset = 3'd1;

  localparam logic [31:0] ColGreen = 32'hFF00_FF00;
  localparam logic [31:0] ColYellow = 32'hFFFF_FF00;
  localparam logic [31:0] ColBlue = 32'hFF00_00FF;
  localparam logic [31:0] ColPink = 32'hFFFF_00FF;
  localparam logic [31:0] ColCyan = 32'hFF00_FFFF;
  localparam logic [31:0] ColRed = 32'hFFFF_0000;
  localparam logic [31:0] ColWhite = 32'hFFFF_FFFF;

  localparam logic [LevelW-1:0] Lvl1 = 3'd1;
  localparam logic [LevelW-1:0] Lvl2 = 3'd2;
  localparam logic [LevelW-1:0] Lvl3 = 3'd3;
  localparam logic [LevelW-1:0] Lvl4 = 3'd4;
  localparam logic [LevelW-1:0] Lvl5 = 3'd5;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [DevIdxW-1:0] device_index;
  } dhm_req_t;

  typedef struct packed {
    logic [CntW-1:0]       offline_count;
    logic [LevelW-1:0]     top_level;
    logic [CntW-1:0]       top_level_count;
    logic [MaxDevices-1:0] online_mask;
    logic [31:0]           status_colour;
  } dhm_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } dhm_state_e;

endpackage

// File: design/dhm_cmp.sv
// Shared elapsed-time unit: wrapped subtract and threshold compare,
// used once per device during a scan. Depends on dhm_pkg.
module dhm_cmp (
  input  logic [dhm_pkg::TimeW-1:0] now_i,
  input  logic [dhm_pkg::TimeW-1:0] last_i,
  input  logic [dhm_pkg::ThrW-1:0]  thr_i,
  output logic                      offline_o
);

  logic [dhm_pkg::TimeW-1:0] elapsed;

  assign elapsed   = now_i - last_i;
  assign offline_o = elapsed > {{(dhm_pkg::TimeW - dhm_pkg::ThrW){1'b0}}, thr_i};

endmodule

// File: design/dhm_colour.sv
// Status colour select from offline count, top level and link flags.
// Depends on dhm_pkg.
module dhm_colour (
  input  logic [dhm_pkg::CntW-1:0]   offline_i,
  input  logic [dhm_pkg::LevelW-1:0] top_i,
  input  logic                       aim_online_i,
  input  logic                       referee_online_i,
  output logic [31:0]                colour_o
);

  always_comb begin
    if (offline_i == '0) begin
      colour_o = dhm_pkg::ColGreen;
    end else begin
      unique case (top_i)
        dhm_pkg::Lvl1: begin
          colour_o = (!aim_online_i && !referee_online_i) ? dhm_pkg::ColYellow
                                                          : dhm_pkg::ColGreen;
        end
        dhm_pkg::Lvl2: colour_o = dhm_pkg::ColBlue;
        dhm_pkg::Lvl3: colour_o = dhm_pkg::ColPink;
        dhm_pkg::Lvl4: colour_o = dhm_pkg::ColCyan;
        dhm_pkg::Lvl5: colour_o = dhm_pkg::ColRed;
        default:       colour_o = dhm_pkg::ColWhite;
      endcase
    end
  end

endmodule

// File: design/device_heartbeat_monitor_top.sv
// Heartbeat monitor top: config registers, time base, last-seen store,
// scan sequencer. Depends on dhm_pkg, dhm_cmp, dhm_colour.
// Heartbeat and tick requests take effect at the accepting edge; busy stays low.
// A scan keeps busy high through ST_SCAN and ST_DONE: the shared compare unit checks
// one device per cycle, then ST_DONE registers the result. res_valid_o pulses in the
// next cycle, for one cycle; the receiver cannot stall. A new request may start then.
// Reset (async, active low) clears time, last-seen stamps and online flags.
module device_heartbeat_monitor_top #(
  parameter int unsigned NUM_DEVICES = dhm_pkg::DefNumDevices
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  dhm_pkg::dhm_req_t             req_i,
  output logic                          res_valid_o,
  output dhm_pkg::dhm_res_t             res_o,
  input  logic                          cfg_we_i,
  input  logic [dhm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dhm_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned IdxW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_DEVICES - 1);

  logic [63:0]                     thr_lo_q, thr_hi_q;
  logic [23:0]                     levels_q;
  logic [dhm_pkg::DevIdxW-1:0]     aim_q, referee_q;
  logic [dhm_pkg::TimeW-1:0]       now_q;
  logic [dhm_pkg::TimeW-1:0]       last_q [NUM_DEVICES];
  logic [dhm_pkg::MaxDevices-1:0]  flags_q;

  dhm_pkg::dhm_state_e             state_q, state_d;
  logic [IdxW-1:0]                 idx_q;
  logic [dhm_pkg::CntW-1:0]        off_q, topcnt_q;
  logic [dhm_pkg::LevelW-1:0]      top_q;
  logic                            res_valid_q;
  dhm_pkg::dhm_res_t               res_q;

  logic                            accept;
  logic [dhm_pkg::DevIdxW-1:0]     dev;
  logic [127:0]                    thr_all;
  logic [dhm_pkg::ThrW-1:0]        thr;
  logic [dhm_pkg::LevelW-1:0]      lvl;
  logic                            dev_off;
  logic [31:0]                     colour;

  assign accept = start && !busy;
  assign busy   = (state_q != dhm_pkg::ST_IDLE);
  assign dev    = dhm_pkg::DevIdxW'(idx_q);
  assign thr_all = {thr_hi_q, thr_lo_q};
  assign thr    = thr_all[dev*dhm_pkg::ThrW +: dhm_pkg::ThrW];
  assign lvl    = levels_q[dev*dhm_pkg::LevelW +: dhm_pkg::LevelW];

  dhm_cmp u_cmp (
    .now_i    (now_q),
    .last_i   (last_q[idx_q]),
    .thr_i    (thr),
    .offline_o(dev_off)
  );

  dhm_colour u_colour (
    .offline_i       (off_q),
    .top_i           (top_q),
    .aim_online_i    (flags_q[aim_q]),
    .referee_online_i(flags_q[referee_q]),
    .colour_o        (colour)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_lo_q  <= dhm_pkg::ThrReset;
      thr_hi_q  <= dhm_pkg::ThrReset;
      levels_q  <= '0;
      aim_q     <= dhm_pkg::AimReset;
      referee_q <= dhm_pkg::RefereeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dhm_pkg::RegThrLow:  thr_lo_q  <= cfg_data_i;
        dhm_pkg::RegThrHigh: thr_hi_q  <= cfg_data_i;
        dhm_pkg::RegLevels:  levels_q  <= cfg_data_i[23:0];
        dhm_pkg::RegAim:     aim_q     <= cfg_data_i[dhm_pkg::DevIdxW-1:0];
        dhm_pkg::RegReferee: referee_q <= cfg_data_i[dhm_pkg::DevIdxW-1:0];
        default: ;
      endcase
    end
  end

  // time base and last-seen stamps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
      for (int k = 0; k < NUM_DEVICES; k++) begin
        last_q[k] <= '0;
      end
    end else if (accept) begin
      if (req_i.req_type == dhm_pkg::ReqTick) begin
        now_q <= now_q + dhm_pkg::TimeW'(1);
      end
      if (req_i.req_type == dhm_pkg::ReqBeat &&
          {1'b0, req_i.device_index} < (dhm_pkg::DevIdxW + 1)'(NUM_DEVICES)) begin
        last_q[req_i.device_index[IdxW-1:0]] <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dhm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dhm_pkg::ST_IDLE: begin
        if (accept && req_i.req_type == dhm_pkg::ReqScan) state_d = dhm_pkg::ST_SCAN;
      end
      dhm_pkg::ST_SCAN: begin
        if (idx_q == LastIdx) state_d = dhm_pkg::ST_DONE;
      end
      dhm_pkg::ST_DONE: state_d = dhm_pkg::ST_IDLE;
      default:          state_d = dhm_pkg::ST_IDLE;
    endcase
  end

  // scan accumulators and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      off_q    <= '0;
      top_q    <= '0;
      topcnt_q <= '0;
      flags_q  <= '0;
    end else if (state_q == dhm_pkg::ST_IDLE) begin
      idx_q    <= '0;
      off_q    <= '0;
      top_q    <= '0;
      topcnt_q <= '0;
    end else if (state_q == dhm_pkg::ST_SCAN) begin
      idx_q        <= idx_q + IdxW'(1);
      flags_q[dev] <= !dev_off;
      if (dev_off) begin
        off_q <= off_q + dhm_pkg::CntW'(1);
        if (lvl > top_q) begin
          top_q    <= lvl;
          topcnt_q <= dhm_pkg::CntW'(1);
        end else if (lvl == top_q) begin
          topcnt_q <= topcnt_q + dhm_pkg::CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (state_q == dhm_pkg::ST_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dhm_pkg::ST_DONE) begin
      res_q.offline_count   <= off_q;
      res_q.top_level       <= top_q;
      res_q.top_level_count <= topcnt_q;
      res_q.online_mask     <= flags_q;
      res_q.status_colour   <= colour;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
